/* sv/pwfe_pkg.sv */
// ----------------------------------------------------------------------------
// Pixel write and fill engine package
// Shared constants, command and register codes, the configuration record and
// the colour channel scaling function.
// ----------------------------------------------------------------------------
package pwfe_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int ADDR_BITS_DEF  = 64;
   localparam int FRAME_BITS     = 16;
   localparam int PITCH_BITS     = 18;
   localparam int LAYOUT_BITS    = 13;
   localparam int LEVEL_BITS     = 8;
   localparam int COLOR_BITS     = 32;
   localparam int CLEAR_BITS     = 32;
   localparam int CMD_BITS       = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   localparam logic [CMD_BITS-1:0] CMD_PUT_PIXEL   = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_START_FILL  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_START_CLEAR = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_STEP        = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISPLAY_ENABLE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_ADDRESS   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_PITCH      = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RED_LAYOUT     = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GREEN_LAYOUT   = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLUE_LAYOUT    = 3'd7;

   typedef struct packed {
      logic                     display_enable;
      logic [CSR_DATA_BITS-1:0] base_address;
      logic [FRAME_BITS-1:0]    frame_width;
      logic [FRAME_BITS-1:0]    frame_height;
      logic [PITCH_BITS-1:0]    row_pitch;
      logic [LAYOUT_BITS-1:0]   red_layout;
      logic [LAYOUT_BITS-1:0]   green_layout;
      logic [LAYOUT_BITS-1:0]   blue_layout;
   } cfg_type;

   // The division by 255 uses (v + 1 + (v >> 8)) >> 8, which is exact for
   // every product of two eight-bit values.
   function automatic logic [COLOR_BITS-1:0] scale_channel(
      input logic [LEVEL_BITS-1:0]  level,
      input logic [LAYOUT_BITS-1:0] layout
   );
      logic [4:0]            pos;
      logic [3:0]            size;
      logic [LEVEL_BITS:0]   mask_wide;
      logic [15:0]           prod;
      logic [15:0]           sum;
      logic [COLOR_BITS-1:0] wide;
      pos = layout[4:0];
      size = layout[11:8];
      if (size > 4'd8) begin
         size = 4'd8;
      end
      mask_wide = (9'd1 << size) - 9'd1;
      prod = {8'd0, level} * {8'd0, mask_wide[LEVEL_BITS-1:0]};
      sum = prod + 16'd1 + {8'd0, prod[15:8]};
      wide = {24'd0, sum[15:8]} << pos;
      return wide;
   endfunction

endpackage

/* sv/pwfe_csr.sv */
// ----------------------------------------------------------------------------
// Pixel write and fill engine configuration registers
// Holds the frame geometry, base address and colour layout written through
// the configuration channel.
// ----------------------------------------------------------------------------
module pwfe_csr import pwfe_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DISPLAY_ENABLE: cfg_in.display_enable = csr_data[0];
            CSR_BASE_ADDRESS:   cfg_in.base_address = csr_data;
            CSR_FRAME_WIDTH:    cfg_in.frame_width = csr_data[FRAME_BITS-1:0];
            CSR_FRAME_HEIGHT:   cfg_in.frame_height = csr_data[FRAME_BITS-1:0];
            CSR_ROW_PITCH:      cfg_in.row_pitch = csr_data[PITCH_BITS-1:0];
            CSR_RED_LAYOUT:     cfg_in.red_layout = csr_data[LAYOUT_BITS-1:0];
            CSR_GREEN_LAYOUT:   cfg_in.green_layout = csr_data[LAYOUT_BITS-1:0];
            CSR_BLUE_LAYOUT:    cfg_in.blue_layout = csr_data[LAYOUT_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* sv/pwfe_color.sv */
// ----------------------------------------------------------------------------
// Pixel write and fill engine colour packer
// Scales the three eight-bit channels to their field sizes and places them
// at their field positions in one 32-bit pixel word.
// ----------------------------------------------------------------------------
module pwfe_color import pwfe_pkg::*; (
   input  cfg_type               cfg,
   input  logic [LEVEL_BITS-1:0] red_level,
   input  logic [LEVEL_BITS-1:0] green_level,
   input  logic [LEVEL_BITS-1:0] blue_level,
   output logic [COLOR_BITS-1:0] color
);

   assign color = scale_channel(red_level, cfg.red_layout)
                | scale_channel(green_level, cfg.green_layout)
                | scale_channel(blue_level, cfg.blue_layout);

endmodule

/* sv/pwfe_engine.sv */
// ----------------------------------------------------------------------------
// Pixel write and fill engine datapath
// Input register, preparation register (product, clipping, colour) and the
// run state with the result register.
// ----------------------------------------------------------------------------
module pwfe_engine import pwfe_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CMD_BITS-1:0]   req_cmd,
   input  logic [COORD_BITS-1:0] req_pos_x,
   input  logic [COORD_BITS-1:0] req_pos_y,
   input  logic [COORD_BITS-1:0] req_rect_width,
   input  logic [COORD_BITS-1:0] req_rect_height,
   input  logic [LEVEL_BITS-1:0] req_red_in,
   input  logic [LEVEL_BITS-1:0] req_green_in,
   input  logic [LEVEL_BITS-1:0] req_blue_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ADDR_BITS-1:0]  rsp_write_address,
   output logic [COLOR_BITS-1:0] rsp_write_data,
   output logic                  rsp_run_last
);

   localparam int LW = ((COORD_BITS > FRAME_BITS) ? COORD_BITS : FRAME_BITS) + 1;
   localparam int PW = COORD_BITS + PITCH_BITS;

   // Input register.
   logic                  a_valid_ff;
   logic [CMD_BITS-1:0]   a_cmd_ff;
   logic [COORD_BITS-1:0] a_x_ff;
   logic [COORD_BITS-1:0] a_y_ff;
   logic [COORD_BITS-1:0] a_w_ff;
   logic [COORD_BITS-1:0] a_h_ff;
   logic [LEVEL_BITS-1:0] a_red_ff;
   logic [LEVEL_BITS-1:0] a_green_ff;
   logic [LEVEL_BITS-1:0] a_blue_ff;

   // Preparation register.
   logic                  b_valid_ff;
   logic [CMD_BITS-1:0]   b_cmd_ff;
   logic [COORD_BITS-1:0] b_x_ff;
   logic [COORD_BITS-1:0] b_y_ff;
   logic [PW-1:0]         b_prod_ff;
   logic                  b_in_frame_ff;
   logic                  b_fill_ok_ff;
   logic [FRAME_BITS-1:0] b_col_lim_ff;
   logic [FRAME_BITS-1:0] b_row_lim_ff;
   logic [CLEAR_BITS-1:0] b_total_ff;
   logic [COLOR_BITS-1:0] b_color_ff;

   // Run state.
   logic                  run_active_ff;
   logic                  run_active_in;
   logic                  run_is_clear_ff;
   logic                  run_is_clear_in;
   logic [COLOR_BITS-1:0] run_color_ff;
   logic [COLOR_BITS-1:0] run_color_in;
   logic [ADDR_BITS-1:0]  row_start_ff;
   logic [ADDR_BITS-1:0]  row_start_in;
   logic [COORD_BITS-1:0] start_col_ff;
   logic [COORD_BITS-1:0] start_col_in;
   logic [COORD_BITS-1:0] cur_col_ff;
   logic [COORD_BITS-1:0] cur_col_in;
   logic [COORD_BITS-1:0] cur_row_ff;
   logic [COORD_BITS-1:0] cur_row_in;
   logic [FRAME_BITS-1:0] col_lim_ff;
   logic [FRAME_BITS-1:0] col_lim_in;
   logic [FRAME_BITS-1:0] row_lim_ff;
   logic [FRAME_BITS-1:0] row_lim_in;
   logic [CLEAR_BITS-1:0] clear_idx_ff;
   logic [CLEAR_BITS-1:0] clear_idx_in;
   logic [CLEAR_BITS-1:0] clear_total_ff;
   logic [CLEAR_BITS-1:0] clear_total_in;

   // Result register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [ADDR_BITS-1:0]  rsp_addr_ff;
   logic [COLOR_BITS-1:0] rsp_data_ff;
   logic                  rsp_last_ff;

   logic c_ready;
   logic b_ready;
   logic a_ready;
   logic b_fire;

   // Preparation logic.
   logic [COLOR_BITS-1:0] color;
   logic [PW-1:0]         prod;
   logic [LW-1:0]         x_ext;
   logic [LW-1:0]         y_ext;
   logic [LW-1:0]         fw_ext;
   logic [LW-1:0]         fh_ext;
   logic [LW-1:0]         x_plus_w;
   logic [LW-1:0]         y_plus_h;
   logic [LW-1:0]         col_lim_wide;
   logic [LW-1:0]         row_lim_wide;
   logic                  in_frame;
   logic [CLEAR_BITS-1:0] total;

   // Execute logic.
   logic [ADDR_BITS+PW-1:0]           prod_ext;
   logic [ADDR_BITS+COORD_BITS+1:0]   x_off_ext;
   logic [ADDR_BITS+COORD_BITS+1:0]   col_off_ext;
   logic [ADDR_BITS+CLEAR_BITS+1:0]   idx_off_ext;
   logic [ADDR_BITS+PITCH_BITS-1:0]   pitch_ext;
   logic [ADDR_BITS-1:0]              row_addr;
   logic [ADDR_BITS-1:0]              pixel_addr;
   logic [CLEAR_BITS:0]               idx_next;
   logic                              clear_last;
   logic [LW-1:0]                     col_next;
   logic [LW-1:0]                     row_next;
   logic                              row_end;
   logic                              fill_last;
   logic                              emit;
   logic [ADDR_BITS-1:0]              emit_addr;
   logic [COLOR_BITS-1:0]             emit_data;
   logic                              emit_last;

   assign c_ready   = !rsp_valid_ff || !rsp_stall;
   assign b_ready   = !b_valid_ff || c_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign b_fire    = b_valid_ff && c_ready;
   assign req_stall = !a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && a_ready) begin
         a_cmd_ff   <= req_cmd;
         a_x_ff     <= req_pos_x;
         a_y_ff     <= req_pos_y;
         a_w_ff     <= req_rect_width;
         a_h_ff     <= req_rect_height;
         a_red_ff   <= req_red_in;
         a_green_ff <= req_green_in;
         a_blue_ff  <= req_blue_in;
      end
   end

   pwfe_color u_color (
      .cfg         (cfg),
      .red_level   (a_red_ff),
      .green_level (a_green_ff),
      .blue_level  (a_blue_ff),
      .color       (color)
   );

   assign prod     = {{PITCH_BITS{1'b0}}, a_y_ff} * {{COORD_BITS{1'b0}}, cfg.row_pitch};
   assign x_ext    = {{(LW-COORD_BITS){1'b0}}, a_x_ff};
   assign y_ext    = {{(LW-COORD_BITS){1'b0}}, a_y_ff};
   assign fw_ext   = {{(LW-FRAME_BITS){1'b0}}, cfg.frame_width};
   assign fh_ext   = {{(LW-FRAME_BITS){1'b0}}, cfg.frame_height};
   assign x_plus_w = x_ext + {{(LW-COORD_BITS){1'b0}}, a_w_ff};
   assign y_plus_h = y_ext + {{(LW-COORD_BITS){1'b0}}, a_h_ff};
   assign col_lim_wide = (x_plus_w < fw_ext) ? x_plus_w : fw_ext;
   assign row_lim_wide = (y_plus_h < fh_ext) ? y_plus_h : fh_ext;
   assign in_frame = (x_ext < fw_ext) && (y_ext < fh_ext);
   assign total    = {16'd0, cfg.row_pitch[PITCH_BITS-1:2]} * {16'd0, cfg.frame_height};

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff && b_ready) begin
         b_cmd_ff      <= a_cmd_ff;
         b_x_ff        <= a_x_ff;
         b_y_ff        <= a_y_ff;
         b_prod_ff     <= prod;
         b_in_frame_ff <= in_frame;
         b_fill_ok_ff  <= in_frame && (a_w_ff != '0) && (a_h_ff != '0);
         b_col_lim_ff  <= col_lim_wide[FRAME_BITS-1:0];
         b_row_lim_ff  <= row_lim_wide[FRAME_BITS-1:0];
         b_total_ff    <= total;
         b_color_ff    <= color;
      end
   end

   assign prod_ext    = {{ADDR_BITS{1'b0}}, b_prod_ff};
   assign x_off_ext   = {{ADDR_BITS{1'b0}}, b_x_ff, 2'b00};
   assign col_off_ext = {{ADDR_BITS{1'b0}}, cur_col_ff, 2'b00};
   assign idx_off_ext = {{ADDR_BITS{1'b0}}, clear_idx_ff, 2'b00};
   assign pitch_ext   = {{ADDR_BITS{1'b0}}, cfg.row_pitch};
   assign row_addr    = cfg.base_address[ADDR_BITS-1:0] + prod_ext[ADDR_BITS-1:0];
   assign pixel_addr  = row_addr + x_off_ext[ADDR_BITS-1:0];
   assign idx_next    = {1'b0, clear_idx_ff} + {{CLEAR_BITS{1'b0}}, 1'b1};
   assign clear_last  = idx_next >= {1'b0, clear_total_ff};
   assign col_next    = {{(LW-COORD_BITS){1'b0}}, cur_col_ff} + {{(LW-1){1'b0}}, 1'b1};
   assign row_next    = {{(LW-COORD_BITS){1'b0}}, cur_row_ff} + {{(LW-1){1'b0}}, 1'b1};
   assign row_end     = col_next >= {{(LW-FRAME_BITS){1'b0}}, col_lim_ff};
   assign fill_last   = row_end && (row_next >= {{(LW-FRAME_BITS){1'b0}}, row_lim_ff});

   always_comb begin
      run_active_in   = run_active_ff;
      run_is_clear_in = run_is_clear_ff;
      run_color_in    = run_color_ff;
      row_start_in    = row_start_ff;
      start_col_in    = start_col_ff;
      cur_col_in      = cur_col_ff;
      cur_row_in      = cur_row_ff;
      col_lim_in      = col_lim_ff;
      row_lim_in      = row_lim_ff;
      clear_idx_in    = clear_idx_ff;
      clear_total_in  = clear_total_ff;
      emit            = 1'b0;
      emit_addr       = pixel_addr;
      emit_data       = b_color_ff;
      emit_last       = 1'b1;
      if (b_fire && cfg.display_enable) begin
         case (b_cmd_ff)
            CMD_PUT_PIXEL: begin
               emit = b_in_frame_ff;
            end
            CMD_START_FILL: begin
               run_active_in = b_fill_ok_ff;
               if (b_fill_ok_ff) begin
                  col_lim_in      = b_col_lim_ff;
                  row_lim_in      = b_row_lim_ff;
                  start_col_in    = b_x_ff;
                  cur_col_in      = b_x_ff;
                  cur_row_in      = b_y_ff;
                  row_start_in    = row_addr;
                  run_color_in    = b_color_ff;
                  run_is_clear_in = 1'b0;
               end
            end
            CMD_START_CLEAR: begin
               run_active_in = (b_total_ff != '0);
               if (b_total_ff != '0) begin
                  clear_total_in  = b_total_ff;
                  clear_idx_in    = '0;
                  row_start_in    = cfg.base_address[ADDR_BITS-1:0];
                  run_color_in    = b_color_ff;
                  run_is_clear_in = 1'b1;
               end
            end
            CMD_STEP: begin
               if (run_active_ff) begin
                  emit      = 1'b1;
                  emit_data = run_color_ff;
                  if (run_is_clear_ff) begin
                     emit_addr    = row_start_ff + idx_off_ext[ADDR_BITS-1:0];
                     emit_last    = clear_last;
                     clear_idx_in = idx_next[CLEAR_BITS-1:0];
                     if (clear_last) begin
                        run_active_in = 1'b0;
                     end
                  end else begin
                     emit_addr = row_start_ff + col_off_ext[ADDR_BITS-1:0];
                     emit_last = fill_last;
                     if (row_end) begin
                        cur_col_in   = start_col_ff;
                        cur_row_in   = row_next[COORD_BITS-1:0];
                        row_start_in = row_start_ff + pitch_ext[ADDR_BITS-1:0];
                     end else begin
                        cur_col_in = col_next[COORD_BITS-1:0];
                     end
                     if (fill_last) begin
                        run_active_in = 1'b0;
                     end
                  end
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid_in = c_ready ? (b_fire && emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_active_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         run_active_ff <= run_active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_is_clear_ff <= run_is_clear_in;
      run_color_ff    <= run_color_in;
      row_start_ff    <= row_start_in;
      start_col_ff    <= start_col_in;
      cur_col_ff      <= cur_col_in;
      cur_row_ff      <= cur_row_in;
      col_lim_ff      <= col_lim_in;
      row_lim_ff      <= row_lim_in;
      clear_idx_ff    <= clear_idx_in;
      clear_total_ff  <= clear_total_in;
      if (b_fire && emit) begin
         rsp_addr_ff <= emit_addr;
         rsp_data_ff <= emit_data;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_address = rsp_addr_ff;
   assign rsp_write_data    = rsp_data_ff;
   assign rsp_run_last      = rsp_last_ff;

endmodule

/* sv/pixel_write_and_fill_engine.sv */
// ----------------------------------------------------------------------------
// Pixel write and fill engine
// Turns put-pixel, rectangle-fill, clear and step commands into framebuffer
// word writes with packed pixel colours.
//
// The request channel takes one command item per cycle while req_stall is low
// (req_valid with req_stall). Put-pixel gives one write at once if in frame;
// a fill or clear start gives no write and arms a run, and each later step
// item gives one write of that run, the final one marked by rsp_run_last.
// Disabled display drops items. The response channel (rsp_valid with
// rsp_stall) carries the write address and data. An item passes the input
// register, the preparation register holding the row product and clipping,
// then the run state and result register. When the receiver stalls, the
// result register holds and the two stages in front of it keep filling, so
// req_stall rises only when all three are full. The configuration channel is
// always ready; the user must write it only while idle, which the block does
// not enforce. Reset clears the registers, the run and all pipeline valids.
// ----------------------------------------------------------------------------
module pixel_write_and_fill_engine import pwfe_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [CMD_BITS-1:0]       req_cmd,
   input  logic [COORD_BITS-1:0]     req_pos_x,
   input  logic [COORD_BITS-1:0]     req_pos_y,
   input  logic [COORD_BITS-1:0]     req_rect_width,
   input  logic [COORD_BITS-1:0]     req_rect_height,
   input  logic [LEVEL_BITS-1:0]     req_red_in,
   input  logic [LEVEL_BITS-1:0]     req_green_in,
   input  logic [LEVEL_BITS-1:0]     req_blue_in,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [ADDR_BITS-1:0]      rsp_write_address,
   output logic [COLOR_BITS-1:0]     rsp_write_data,
   output logic                      rsp_run_last
);

   cfg_type cfg;

   pwfe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pwfe_engine #(
      .COORD_BITS (COORD_BITS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_rect_width    (req_rect_width),
      .req_rect_height   (req_rect_height),
      .req_red_in        (req_red_in),
      .req_green_in      (req_green_in),
      .req_blue_in       (req_blue_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_address (rsp_write_address),
      .rsp_write_data    (rsp_write_data),
      .rsp_run_last      (rsp_run_last)
   );

endmodule

/* sv/pwfe_checker.sv */
// ----------------------------------------------------------------------------
// Pixel write and fill engine port checker
// Watches the request and response ports of the top level over time.
// ----------------------------------------------------------------------------
module pwfe_checker import pwfe_pkg::*; #(
   parameter int ADDR_BITS = ADDR_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [ADDR_BITS-1:0]  rsp_write_address,
   input logic [COLOR_BITS-1:0] rsp_write_data,
   input logic                  rsp_run_last
);

   // A stalled result stays on the port unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_write_address)
         && $stable(rsp_write_data) && $stable(rsp_run_last))
      else $error("stalled result changed");

   // Nothing is offered straight after reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result offered after reset");

   // With the result register empty the pipeline always has room.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with an empty result register");

   // Back-pressure is raised only behind a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled result");

   // A stalled request item is held until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("stalled request withdrawn");

endmodule

bind pixel_write_and_fill_engine pwfe_checker #(
   .ADDR_BITS (ADDR_BITS)
) u_pwfe_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_write_address (rsp_write_address),
   .rsp_write_data    (rsp_write_data),
   .rsp_run_last      (rsp_run_last)
);

/* verif/tb_pixel_write_and_fill_engine.sv */
// ----------------------------------------------------------------------------
// Pixel write and fill engine testbench
// Drives put-pixel, rectangle-fill, clear and step items into the engine under
// random idling on both channels and predicts every framebuffer write from a
// behavioural copy of the run state and the registers. Register writes are
// made only after all outstanding writes have drained. A directed section
// covers edges, clipping, address wrap and the disabled display, and random
// phases then run fill and clear sequences over many frame layouts.
// ----------------------------------------------------------------------------
module tb_pixel_write_and_fill_engine;
   import pwfe_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 600;
   localparam int PHASES        = 8;

   typedef enum logic [1:0] {OP_ITEM, OP_REGISTER, OP_SETTLE} op_kind_type;

   typedef struct packed {
      logic [CMD_BITS-1:0] cmd;
      logic [15:0]         pos_x;
      logic [15:0]         pos_y;
      logic [15:0]         rect_width;
      logic [15:0]         rect_height;
      logic [7:0]          red;
      logic [7:0]          green;
      logic [7:0]          blue;
   } draw_item_type;

   typedef struct packed {
      op_kind_type               kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  data;
      draw_item_type             item;
   } stim_op_type;

   typedef struct packed {
      logic [63:0] address;
      logic [31:0] data;
      logic        last;
   } mem_write_type;

   logic                      clock           = 1'b0;
   logic                      reset           = 1'b1;
   logic                      csr_valid       = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index       = CSR_DISPLAY_ENABLE;
   logic [CSR_DATA_BITS-1:0]  csr_data        = '0;
   logic                      req_valid       = 1'b0;
   logic                      req_stall;
   logic [CMD_BITS-1:0]       req_cmd         = CMD_PUT_PIXEL;
   logic [15:0]               req_pos_x       = '0;
   logic [15:0]               req_pos_y       = '0;
   logic [15:0]               req_rect_width  = '0;
   logic [15:0]               req_rect_height = '0;
   logic [7:0]                req_red_in      = '0;
   logic [7:0]                req_green_in    = '0;
   logic [7:0]                req_blue_in     = '0;
   logic                      rsp_valid;
   logic                      rsp_stall       = 1'b0;
   logic [63:0]               rsp_write_address;
   logic [31:0]               rsp_write_data;
   logic                      rsp_run_last;

   pixel_write_and_fill_engine dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_rect_width    (req_rect_width),
      .req_rect_height   (req_rect_height),
      .req_red_in        (req_red_in),
      .req_green_in      (req_green_in),
      .req_blue_in       (req_blue_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_address (rsp_write_address),
      .rsp_write_data    (rsp_write_data),
      .rsp_run_last      (rsp_run_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow registers and run state of the engine.
   cfg_type       model_cfg   = '0;
   logic          run_on      = 1'b0;
   logic          run_clear   = 1'b0;
   logic [31:0]   run_colour  = '0;
   logic [63:0]   row_addr    = '0;
   logic [31:0]   first_col   = '0;
   logic [31:0]   col         = '0;
   logic [31:0]   row         = '0;
   logic [31:0]   col_stop    = '0;
   logic [31:0]   row_stop    = '0;
   logic [31:0]   clear_pos   = '0;
   logic [31:0]   clear_count = '0;
   mem_write_type expected_writes[$];

   stim_op_type   command_queue[$];
   draw_item_type shown_item = '0;
   logic          stimulus_done = 1'b0;
   logic          settling = 1'b0;
   logic          quiet = 1'b0;
   int            gap_left = 0;
   int            settle_left = 0;
   int            stall_left = 0;
   int            quiet_left = 0;
   int            error_count = 0;
   int            items_accepted = 0;
   int            regs_written = 0;
   int            writes_checked = 0;
   int            run_ends = 0;

   int            gen_w = 0;
   int            gen_h = 0;
   int            gen_pitch = 0;
   int            gen_items = 0;
   logic          gen_enabled = 1'b1;

   function automatic logic [31:0] channel_bits(input logic [7:0] level,
                                                input logic [12:0] layout);
      logic [3:0]  field_size;
      logic [63:0] scaled;
      field_size = (layout[11:8] > 4'd8) ? 4'd8 : layout[11:8];
      scaled = {56'd0, level};
      scaled = (scaled * ((64'd1 << field_size) - 64'd1)) / 64'd255;
      scaled = scaled << layout[4:0];
      return scaled[31:0];
   endfunction

   function automatic logic [31:0] pixel_word(input draw_item_type it);
      return channel_bits(it.red, model_cfg.red_layout)
           | channel_bits(it.green, model_cfg.green_layout)
           | channel_bits(it.blue, model_cfg.blue_layout);
   endfunction

   task automatic apply_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] value);
      case (index)
         CSR_DISPLAY_ENABLE: model_cfg.display_enable = value[0];
         CSR_BASE_ADDRESS:   model_cfg.base_address = value;
         CSR_FRAME_WIDTH:    model_cfg.frame_width = value[15:0];
         CSR_FRAME_HEIGHT:   model_cfg.frame_height = value[15:0];
         CSR_ROW_PITCH:      model_cfg.row_pitch = value[17:0];
         CSR_RED_LAYOUT:     model_cfg.red_layout = value[12:0];
         CSR_GREEN_LAYOUT:   model_cfg.green_layout = value[12:0];
         default:            model_cfg.blue_layout = value[12:0];
      endcase
   endtask

   task automatic predict_write(input draw_item_type it);
      logic [63:0]   ycoord;
      logic [63:0]   xcoord;
      logic [63:0]   pitch;
      logic [63:0]   words;
      logic [31:0]   x_end;
      logic [31:0]   y_end;
      logic          row_done;
      logic          done;
      mem_write_type w;
      ycoord = {48'd0, it.pos_y};
      xcoord = {48'd0, it.pos_x};
      pitch = {46'd0, model_cfg.row_pitch};
      if (model_cfg.display_enable) begin
         case (it.cmd)
            CMD_PUT_PIXEL: begin
               if (it.pos_x < model_cfg.frame_width && it.pos_y < model_cfg.frame_height) begin
                  w.address = model_cfg.base_address + ycoord * pitch + xcoord * 64'd4;
                  w.data = pixel_word(it);
                  w.last = 1'b1;
                  expected_writes.push_back(w);
               end
            end
            CMD_START_FILL: begin
               run_on = 1'b0;
               if (it.rect_width != 16'd0 && it.rect_height != 16'd0 &&
                   it.pos_x < model_cfg.frame_width && it.pos_y < model_cfg.frame_height) begin
                  x_end = {16'd0, it.pos_x} + {16'd0, it.rect_width};
                  y_end = {16'd0, it.pos_y} + {16'd0, it.rect_height};
                  col_stop = (x_end < {16'd0, model_cfg.frame_width}) ?
                             x_end : {16'd0, model_cfg.frame_width};
                  row_stop = (y_end < {16'd0, model_cfg.frame_height}) ?
                             y_end : {16'd0, model_cfg.frame_height};
                  first_col = {16'd0, it.pos_x};
                  col = first_col;
                  row = {16'd0, it.pos_y};
                  row_addr = model_cfg.base_address + ycoord * pitch;
                  run_colour = pixel_word(it);
                  run_clear = 1'b0;
                  run_on = 1'b1;
               end
            end
            CMD_START_CLEAR: begin
               words = {48'd0, model_cfg.row_pitch[17:2]} * {48'd0, model_cfg.frame_height};
               run_on = 1'b0;
               if (words != 64'd0) begin
                  clear_count = words[31:0];
                  clear_pos = 32'd0;
                  row_addr = model_cfg.base_address;
                  run_colour = pixel_word(it);
                  run_clear = 1'b1;
                  run_on = 1'b1;
               end
            end
            default: begin
               if (run_on) begin
                  w.data = run_colour;
                  if (run_clear) begin
                     done = ({32'd0, clear_pos} + 64'd1) >= {32'd0, clear_count};
                     w.address = row_addr + {32'd0, clear_pos} * 64'd4;
                     clear_pos = clear_pos + 32'd1;
                  end else begin
                     row_done = (col + 32'd1) >= col_stop;
                     done = row_done && ((row + 32'd1) >= row_stop);
                     w.address = row_addr + {32'd0, col} * 64'd4;
                     if (row_done) begin
                        col = first_col;
                        row = row + 32'd1;
                        row_addr = row_addr + pitch;
                     end else begin
                        col = col + 32'd1;
                     end
                  end
                  w.last = done;
                  if (done) begin
                     run_on = 1'b0;
                  end
                  expected_writes.push_back(w);
               end
            end
         endcase
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      error_count++;
   endtask

   function automatic int pick_pause();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 10);
      end else begin
         return $urandom_range(20, 60);
      end
   endfunction

   always @(posedge clock) begin : command_driver
      stim_op_type op;
      logic        send_item;
      logic        send_reg;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_write(shown_item);
            items_accepted++;
         end
         if (csr_valid && csr_ready) begin
            apply_register(csr_index, csr_data);
            regs_written++;
         end
         if (!(req_valid && req_stall) && !(csr_valid && !csr_ready)) begin
            send_item = 1'b0;
            send_reg = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (settling) begin
               if (expected_writes.size() != 0) begin
                  settle_left = SETTLE_CYCLES;
               end else if (settle_left > 0) begin
                  settle_left--;
               end else begin
                  settling = 1'b0;
               end
            end else if (command_queue.size() != 0) begin
               op = command_queue.pop_front();
               case (op.kind)
                  OP_ITEM: begin
                     send_item = 1'b1;
                     shown_item = op.item;
                     req_cmd <= op.item.cmd;
                     req_pos_x <= op.item.pos_x;
                     req_pos_y <= op.item.pos_y;
                     req_rect_width <= op.item.rect_width;
                     req_rect_height <= op.item.rect_height;
                     req_red_in <= op.item.red;
                     req_green_in <= op.item.green;
                     req_blue_in <= op.item.blue;
                     gap_left = quiet ? 0 : pick_pause();
                  end
                  OP_REGISTER: begin
                     send_reg = 1'b1;
                     csr_index <= op.index;
                     csr_data <= op.data;
                  end
                  default: begin
                     settling = 1'b1;
                     settle_left = SETTLE_CYCLES;
                  end
               endcase
            end else begin
               stimulus_done = 1'b1;
            end
            req_valid <= send_item;
            csr_valid <= send_reg;
         end
      end
   end

   always @(posedge clock) begin : write_monitor
      mem_write_type want;
      int            pause;
      if (reset) begin
         rsp_stall <= 1'b0;
         quiet <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_writes.size() == 0) begin
               report_mismatch("write with none expected", rsp_write_address, '0);
            end else begin
               want = expected_writes.pop_front();
               if (rsp_write_address !== want.address) begin
                  report_mismatch("write_address", rsp_write_address, want.address);
               end
               if (rsp_write_data !== want.data) begin
                  report_mismatch("write_data", {32'd0, rsp_write_data}, {32'd0, want.data});
               end
               if (rsp_run_last !== want.last) begin
                  report_mismatch("run_last", {63'd0, rsp_run_last}, {63'd0, want.last});
               end
               writes_checked++;
               if (want.last) begin
                  run_ends++;
               end
            end
         end
         if (quiet_left == 0) begin
            quiet <= ($urandom_range(0, 3) == 0);
            quiet_left = $urandom_range(50, 300);
         end else begin
            quiet_left--;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            pause = quiet ? 0 : pick_pause();
            rsp_stall <= (pause > 0);
            stall_left = (pause > 0) ? pause - 1 : 0;
         end
      end
   end

   task automatic add_command(input logic [CMD_BITS-1:0] cmd, input int x, input int y,
                              input int w, input int h, input int r, input int g,
                              input int b);
      stim_op_type op;
      op.kind = OP_ITEM;
      op.index = CSR_DISPLAY_ENABLE;
      op.data = '0;
      op.item.cmd = cmd;
      op.item.pos_x = x[15:0];
      op.item.pos_y = y[15:0];
      op.item.rect_width = w[15:0];
      op.item.rect_height = h[15:0];
      op.item.red = r[7:0];
      op.item.green = g[7:0];
      op.item.blue = b[7:0];
      command_queue.push_back(op);
      if (gen_enabled) begin
         gen_items++;
      end
   endtask

   task automatic add_register(input logic [CSR_INDEX_BITS-1:0] index,
                               input logic [CSR_DATA_BITS-1:0] value);
      stim_op_type op;
      op = '0;
      op.kind = OP_REGISTER;
      op.index = index;
      op.data = value;
      command_queue.push_back(op);
   endtask

   task automatic add_settle();
      stim_op_type op;
      op = '0;
      op.kind = OP_SETTLE;
      command_queue.push_back(op);
   endtask

   task automatic add_step();
      add_command(CMD_STEP, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
   endtask

   task automatic add_pixel_near_frame();
      if ($urandom_range(0, 7) == 0) begin
         add_command(CMD_PUT_PIXEL, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom);
      end else begin
         add_command(CMD_PUT_PIXEL, $urandom_range(0, gen_w), $urandom_range(0, gen_h),
                     $urandom, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   task automatic add_frame_setup(input int w, input int h, input int pitch,
                                  input logic [63:0] base, input logic [12:0] red_lay,
                                  input logic [12:0] green_lay, input logic [12:0] blue_lay);
      add_settle();
      add_register(CSR_BASE_ADDRESS, base);
      add_register(CSR_FRAME_WIDTH, 64'(w));
      add_register(CSR_FRAME_HEIGHT, 64'(h));
      add_register(CSR_ROW_PITCH, 64'(pitch));
      add_register(CSR_RED_LAYOUT, 64'(red_lay));
      add_register(CSR_GREEN_LAYOUT, 64'(green_lay));
      add_register(CSR_BLUE_LAYOUT, 64'(blue_lay));
      add_register(CSR_DISPLAY_ENABLE, 64'd1);
      gen_w = w;
      gen_h = h;
      gen_pitch = pitch;
   endtask

   task automatic add_run_steps(input longint run_len);
      int n;
      int k;
      n = (run_len <= 60) ? int'(run_len) + $urandom_range(0, 2) : $urandom_range(1, 30);
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(0, n);
      end
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            add_pixel_near_frame();
         end
         if (k == n / 2 && $urandom_range(0, 7) == 0) begin
            add_settle();
            gen_pitch = $urandom_range(0, 80);
            add_register(CSR_ROW_PITCH, 64'(gen_pitch));
         end
         add_step();
      end
   endtask

   function automatic logic [12:0] random_layout();
      logic [12:0] lay;
      if ($urandom_range(0, 1) == 0) begin
         lay = 13'($urandom_range(0, 8191));
      end else begin
         lay = 13'(($urandom_range(1, 8) << 8) | $urandom_range(0, 24));
      end
      return lay;
   endfunction

   initial begin : stimulus
      int          phase;
      int          mode;
      int          target;
      int          roll;
      int          x;
      int          y;
      int          w;
      int          h;
      int          k;
      longint      cols;
      longint      rows;
      logic [63:0] base;

      // Small frame: corners, clipping, replacement of runs and empty starts.
      add_frame_setup(2, 2, 8, 64'h0000_0000_1000_0000, 13'h0810, 13'h0808, 13'h0800);
      add_command(CMD_PUT_PIXEL, 0, 0, 0, 0, 255, 255, 255);
      add_command(CMD_PUT_PIXEL, 1, 1, 65535, 65535, 0, 0, 0);
      add_command(CMD_PUT_PIXEL, 65535, 0, 0, 0, 1, 2, 3);
      add_command(CMD_PUT_PIXEL, 0, 65535, 0, 0, 1, 2, 3);
      add_command(CMD_START_FILL, 0, 0, 3, 3, 18, 52, 86);
      add_step();
      add_command(CMD_PUT_PIXEL, 1, 0, 0, 0, 128, 64, 32);
      add_step();
      add_command(CMD_START_FILL, 1, 1, 1, 1, 7, 8, 9);
      add_step();
      add_step();
      add_command(CMD_START_FILL, 0, 0, 0, 2, 1, 1, 1);
      add_command(CMD_START_FILL, 2, 0, 1, 1, 1, 1, 1);
      add_command(CMD_START_CLEAR, 65535, 65535, 65535, 65535, 200, 100, 50);
      add_step();
      add_command(CMD_START_CLEAR, 0, 0, 0, 0, 10, 20, 30);
      repeat (4) add_step();

      // Largest frame with address wrap, oversized fields and a paused run.
      add_frame_setup(65535, 65535, 262143, 64'hFFFF_FFFF_FFFF_FFF0,
                      13'h1FFF, 13'h0A1C, 13'h0000);
      add_command(CMD_PUT_PIXEL, 65534, 65534, 0, 0, 255, 255, 255);
      add_command(CMD_START_FILL, 65533, 65534, 65535, 65535, 255, 0, 128);
      add_step();
      add_step();
      add_step();
      add_command(CMD_START_CLEAR, 0, 0, 0, 0, 90, 180, 45);
      add_step();
      add_settle();
      add_register(CSR_DISPLAY_ENABLE, 64'd0);
      add_step();
      add_command(CMD_PUT_PIXEL, 0, 0, 0, 0, 255, 255, 255);
      add_settle();
      add_register(CSR_DISPLAY_ENABLE, 64'd1);
      add_step();

      for (phase = 0; phase < PHASES; phase++) begin
         mode = $urandom_range(0, 9);
         if (mode == 0) begin
            w = ($urandom_range(0, 1) == 0) ? 0 : 5;
            h = (w == 0) ? 4 : 0;
            k = $urandom_range(0, 40);
         end else if (mode == 1) begin
            w = $urandom_range(1000, 65535);
            h = $urandom_range(1000, 65535);
            k = $urandom_range(0, 262143);
         end else begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            k = ($urandom_range(0, 3) != 0) ? w * 4 + 4 * $urandom_range(0, 2)
                                             : $urandom_range(0, 63);
         end
         base = ($urandom_range(0, 3) == 0) ? (64'hFFFF_FFFF_FFFF_FF00 | $urandom_range(0, 255))
                                             : {$urandom, $urandom};
         add_frame_setup(w, h, k, base, random_layout(), random_layout(), random_layout());
         target = gen_items + RANDOM_ITEMS / PHASES;
         while (gen_items < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
               if ($urandom_range(0, 9) == 0) begin
                  x = $urandom_range(0, 65535);
                  y = $urandom_range(0, 65535);
                  w = $urandom_range(0, 65535);
                  h = $urandom_range(0, 65535);
               end else begin
                  x = $urandom_range(0, gen_w);
                  y = $urandom_range(0, gen_h);
                  w = $urandom_range(0, 10);
                  h = $urandom_range(0, 6);
               end
               add_command(CMD_START_FILL, x, y, w, h, $urandom, $urandom, $urandom);
               if (w != 0 && h != 0 && x < gen_w && y < gen_h) begin
                  cols = longint'(((x + w < gen_w) ? x + w : gen_w) - x);
                  rows = longint'(((y + h < gen_h) ? y + h : gen_h) - y);
               end else begin
                  cols = 0;
                  rows = 0;
               end
               add_run_steps(cols * rows);
            end else if (roll < 65) begin
               add_command(CMD_START_CLEAR, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom);
               cols = longint'(gen_pitch / 4);
               rows = longint'(gen_h);
               add_run_steps(cols * rows);
            end else if (roll < 85) begin
               add_pixel_near_frame();
            end else if (roll < 92) begin
               add_settle();
               add_register(CSR_DISPLAY_ENABLE, 64'd0);
               gen_enabled = 1'b0;
               repeat (3) begin
                  add_command(CMD_BITS'($urandom_range(0, 3)), $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom, $urandom);
               end
               add_settle();
               add_register(CSR_DISPLAY_ENABLE, 64'd1);
               gen_enabled = 1'b1;
            end else begin
               add_command(CMD_BITS'($urandom_range(0, 3)), $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom, $urandom);
            end
         end
      end
      add_settle();

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done);
      @(posedge clock);
      if (expected_writes.size() != 0) begin
         report_mismatch("writes never issued", 64'(expected_writes.size()), 64'd0);
      end
      $display("covered %0d command items and %0d register writes over %0d random layouts",
               items_accepted, regs_written, PHASES);
      $display("checked %0d framebuffer writes, %0d of them single pixels or run ends",
               writes_checked, run_ends);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("timeout with %0d writes outstanding", expected_writes.size());
      $display("status: fail");
      $finish;
   end

endmodule

/* filelist.f */
sv/pwfe_pkg.sv
sv/pwfe_csr.sv
sv/pwfe_color.sv
sv/pwfe_engine.sv
sv/pixel_write_and_fill_engine.sv
sv/pwfe_checker.sv
verif/tb_pixel_write_and_fill_engine.sv
